FILE: src/hex_dump_line_to_bytes_core_macros.svh
// ----------------------------------------------------------------------------
// Hex dump line to bytes: assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef HEX_DUMP_LINE_TO_BYTES_CORE_MACROS_SVH
`define HEX_DUMP_LINE_TO_BYTES_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define HEXDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HEXDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hexdl_pkg.sv
// ----------------------------------------------------------------------------
// Hex dump line to bytes: package
// Shared types and constants of the front and back parts.
// ----------------------------------------------------------------------------
package hexdl_pkg;

	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [5:0] HALF_WIDTH_RESET = 6'd24;
	localparam logic [3:0] DIV_WIDTH_RESET  = 4'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_WIDTH  = 2'd1;

	// One classified character, as it travels from front to back.
	typedef struct packed {
		logic       is_nl;
		logic       is_space;
		logic       is_hex;
		logic [3:0] nibble;
	} char_class_t;

	typedef struct packed {
		logic [5:0] half_width;
		logic [3:0] div_width;
	} cfg_t;

	typedef enum logic [5:0] {
		PH_ADDR    = 6'b000001,
		PH_SPACES  = 6'b000010,
		PH_HALF1   = 6'b000100,
		PH_DIVIDER = 6'b001000,
		PH_HALF2   = 6'b010000,
		PH_REST    = 6'b100000
	} phase_t;

endpackage

FILE: src/hexdl_front.sv
// ----------------------------------------------------------------------------
// Hex dump line to bytes: front part
// Accepts characters, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`include "hex_dump_line_to_bytes_core_macros.svh"

module hexdl_front
	import hexdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	output logic        q_valid,
	input  logic        q_pop,
	output char_class_t q_item
);

	char_class_t cls;
	char_class_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	// Character decode: newline, space and hex digit value.
	always_comb begin
		cls.is_nl    = (in_char == CHAR_NL);
		cls.is_space = (in_char == CHAR_SPACE);
		cls.is_hex   = 1'b0;
		cls.nibble   = 4'd0;
		if (in_char >= 8'h30 && in_char <= 8'h39) begin
			cls.is_hex = 1'b1;
			cls.nibble = in_char[3:0];
		end else if ((in_char >= 8'h61 && in_char <= 8'h66) ||
		             (in_char >= 8'h41 && in_char <= 8'h46)) begin
			cls.is_hex = 1'b1;
			cls.nibble = in_char[3:0] + 4'd9;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`HEXDL_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q != 2'd3, "queue count over depth")
	`HEXDL_ASSERT_IMP(a_pop_nonempty, clk, arst_n, q_pop, cnt_q != 2'd0, "pop from empty queue")
	`HEXDL_ASSERT_NXT(a_ptr_gap, clk, arst_n, cnt_q == 2'd1 && !push && !q_pop,
		(wr_ptr_q != rd_ptr_q) && cnt_q == 2'd1, "queue pointers out of step")

endmodule

FILE: src/hexdl_back.sv
// ----------------------------------------------------------------------------
// Hex dump line to bytes: back part
// Runs the line parser on classified characters and drives the output register.
// ----------------------------------------------------------------------------
`include "hex_dump_line_to_bytes_core_macros.svh"

module hexdl_back
	import hexdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	output logic        q_pop,
	input  char_class_t q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);

	phase_t     phase_q, phase_d;
	logic [6:0] pos_q, pos_d;
	logic [1:0] slot_q, slot_d;
	logic [7:0] nib_q, nib_d;
	logic [1:0] dig_q, dig_d;
	logic [3:0] dl_q, dl_d;
	logic       emit;
	logic [7:0] emit_val;
	logic       done;
	logic       do_half;
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	// One character per cycle while the output register can take a byte; the phases fall through within the cycle.
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		slot_d   = slot_q;
		nib_d    = nib_q;
		dig_d    = dig_q;
		dl_d     = dl_q;
		emit     = 1'b0;
		emit_val = nib_q;
		done     = 1'b0;
		do_half  = 1'b0;
		if (q_item.is_nl) begin
			// A newline closes an open group as its separator, then ends the line.
			emit    = (phase_q == PH_HALF1 || phase_q == PH_HALF2) && (dig_q != 2'd0);
			phase_d = PH_ADDR;
			pos_d   = 7'd0;
			slot_d  = 2'd0;
			nib_d   = 8'd0;
			dig_d   = 2'd0;
			dl_d    = 4'd0;
		end else begin
			if (phase_d == PH_ADDR) begin
				if (q_item.is_space) begin
					phase_d = PH_SPACES;
				end
				done = 1'b1;
			end
			if (!done && phase_d == PH_SPACES) begin
				if (q_item.is_space) begin
					done = 1'b1;
				end else begin
					phase_d = PH_HALF1;
					pos_d   = 7'd0;
					slot_d  = 2'd0;
					nib_d   = 8'd0;
					dig_d   = 2'd0;
				end
			end
			if (!done && phase_d == PH_HALF1) begin
				if (slot_d != 2'd0 || pos_d < {1'b0, cfg.half_width}) begin
					do_half = 1'b1;
					done    = 1'b1;
				end else begin
					phase_d = PH_DIVIDER;
					dl_d    = cfg.div_width;
				end
			end
			if (!done && phase_d == PH_DIVIDER) begin
				if (dl_d != 4'd0) begin
					dl_d = dl_d - 4'd1;
					done = 1'b1;
				end else begin
					phase_d = PH_HALF2;
					pos_d   = 7'd0;
					slot_d  = 2'd0;
					nib_d   = 8'd0;
					dig_d   = 2'd0;
				end
			end
			if (!done && phase_d == PH_HALF2) begin
				if (slot_d != 2'd0 || pos_d < {1'b0, cfg.half_width}) begin
					do_half = 1'b1;
				end else begin
					phase_d = PH_REST;
				end
			end
			if (do_half) begin
				pos_d = pos_d + 7'd1;
				if (slot_d < 2'd2 && q_item.is_hex) begin
					nib_d  = {nib_d[3:0], q_item.nibble};
					dig_d  = dig_d + 2'd1;
					slot_d = slot_d + 2'd1;
				end else begin
					emit     = (dig_d != 2'd0);
					emit_val = nib_d;
					slot_d   = 2'd0;
					nib_d    = 8'd0;
					dig_d    = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR;
			pos_q       <= 7'd0;
			slot_q      <= 2'd0;
			nib_q       <= 8'd0;
			dig_q       <= 2'd0;
			dl_q        <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				slot_q  <= slot_d;
				nib_q   <= nib_d;
				dig_q   <= dig_d;
				dl_q    <= dl_d;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_byte_q <= emit_val;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	`HEXDL_ASSERT_IMP(a_div_phase, clk, arst_n, dl_q != 4'd0, phase_q == PH_DIVIDER,
		"divider count outside divider phase")
	`HEXDL_ASSERT_IMP(a_group_phase, clk, arst_n, slot_q != 2'd0,
		phase_q == PH_HALF1 || phase_q == PH_HALF2, "open group outside a data half")
	`HEXDL_ASSERT_IMP(a_rose_pop, clk, arst_n, $rose(out_valid_q), $past(q_pop),
		"byte produced without a consumed character")

endmodule

FILE: src/hex_dump_line_to_bytes_core.sv
// ----------------------------------------------------------------------------
// Hex dump line to bytes: top level
// Turns hex dump text, one character per item, back into the dumped bytes.
// ----------------------------------------------------------------------------
// Usage: characters enter on the s_axis channel, one item per character.
// Each line is parsed as an address, spaces, a first data half of half_width
// characters, divider_width skipped characters and a second half; groups of
// up to two hex digits plus one separator give one byte each on m_axis.
// A newline ends the line and also closes a group left open.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 is
// half_width, 1 is divider_width); other indexes are ignored. The user must
// make writes only while the block is idle; the block does not enforce it.
// Path: the character that completes a byte is written into the front queue
// when accepted; the parser works on it as it leaves the queue, and the byte
// is registered in the output register as that character is popped.
// Throughput: one character per cycle unless a byte waits on a stalled m_axis.
// The two-entry queue between front and back and the output register let a
// new character be accepted while a finished byte still waits.
// Reset: arst_n clears the queue, the parser to the address phase, the output
// valid and the registers to half_width 24 and divider_width 2.
// Stalls: when m_axis_tready is low the byte is held, the parser stops while
// a byte waits in the output register, and s_axis_tready drops when the queue
// fills.
// ----------------------------------------------------------------------------
module hex_dump_line_to_bytes_core
	import hexdl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] in_char
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [5:0]           cfg_data
);

	cfg_t        cfg_q;
	logic        q_valid;
	logic        q_pop;
	char_class_t q_item;

	// Configuration registers; the parser reads them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width <= HALF_WIDTH_RESET;
			cfg_q.div_width  <= DIV_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_WIDTH: cfg_q.half_width <= cfg_data;
				CFG_DIV_WIDTH:  cfg_q.div_width  <= cfg_data[3:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front: accepts and classifies characters into the queue.
	hexdl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// Back: line parser and output register.
	hexdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata)
	);

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Hex dump line to bytes: testbench
// Streams hex dump text through the core one character per item and checks
// every restored byte against a cycle-free prediction of the line parser.
// Directed lines come first, then random, mostly well-formed dump lines
// under changing register settings and changing back-pressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hexdl_pkg::*;

	// A byte passes the front queue and the output register after the character
	// that completes it; SETTLE_CYCLES lets a character that completes nothing settle.
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;

	// Register indexes that the core has to ignore.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;    // [7:0] in_char
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;         // [7:0] out_byte
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HALF_WIDTH;
	logic [5:0]           cfg_data = '0;

	// Pacing, set from the sequence and read by the driver and the receiver.
	int   send_gap_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_go = 1'b0;

	// Characters waiting for the driver, and bytes the parser must still give.
	logic [7:0] pending_chars[$];
	logic [7:0] expected_bytes[$];
	// Scratch for building one line of text before it is queued.
	logic [7:0] line_chars[$];

	// Register values as the stimulus generator sees them.
	int gen_half = HALF_WIDTH_RESET;
	int gen_div  = DIV_WIDTH_RESET;

	// Predicted parser state and the predictor's own copy of the registers.
	phase_t     parse_phase   = PH_ADDR;
	logic [6:0] col_in_half   = '0;
	logic [1:0] group_chars   = '0;
	logic [7:0] group_value   = '0;
	logic [1:0] group_digits  = '0;
	logic [3:0] divider_count = '0;
	logic [5:0] model_half    = HALF_WIDTH_RESET;
	logic [3:0] model_div     = DIV_WIDTH_RESET;

	int err_count = 0;
	int chars_in = 0;
	int lines_in = 0;
	int bytes_out = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	hex_dump_line_to_bytes_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Line parser prediction
	// ------------------------------------------------------------------------

	function automatic void drop_group();
		group_chars  = '0;
		group_value  = '0;
		group_digits = '0;
	endfunction

	// One character inside a data half. Up to two hex digits build the group;
	// any other character, or a third digit, closes it and gives the byte if
	// the group held a digit. A lone digit gives its own value.
	function automatic bit take_data_char(input logic [7:0] c, output logic [7:0] b);
		bit         digit;
		bit         emit;
		logic [3:0] v;
		digit = 1'b1;
		v = '0;
		b = '0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 10);
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
		end else begin
			digit = 1'b0;
		end
		col_in_half = col_in_half + 7'd1;
		if (group_chars < 2'd2 && digit) begin
			group_value  = {group_value[3:0], v};
			group_digits = group_digits + 2'd1;
			group_chars  = group_chars + 2'd1;
			return 1'b0;
		end
		emit = (group_digits != 2'd0);
		b = group_value;
		drop_group();
		return emit;
	endfunction

	// Advances the predicted parser by one accepted character. Phases fall
	// through within one character, as an exhausted half hands the same
	// character on to the divider and the divider on to the second half.
	function automatic bit parse_char(input logic [7:0] c, output logic [7:0] b);
		bit emit;
		b = '0;
		if (c == CHAR_NL) begin
			// A newline closes an open group as its separator, then ends the line.
			emit = (parse_phase == PH_HALF1 || parse_phase == PH_HALF2) &&
				(group_digits != 2'd0);
			b = group_value;
			parse_phase = PH_ADDR;
			col_in_half = '0;
			drop_group();
			divider_count = '0;
			return emit;
		end
		if (parse_phase == PH_ADDR) begin
			if (c == CHAR_SPACE)
				parse_phase = PH_SPACES;
			return 1'b0;
		end
		if (parse_phase == PH_SPACES) begin
			if (c == CHAR_SPACE)
				return 1'b0;
			parse_phase = PH_HALF1;
			col_in_half = '0;
			drop_group();
		end
		if (parse_phase == PH_HALF1) begin
			// An open group may run past the end of the half.
			if (group_chars != 2'd0 || col_in_half < {1'b0, model_half})
				return take_data_char(c, b);
			parse_phase = PH_DIVIDER;
			divider_count = model_div;
		end
		if (parse_phase == PH_DIVIDER) begin
			if (divider_count != 4'd0) begin
				divider_count = divider_count - 4'd1;
				return 1'b0;
			end
			parse_phase = PH_HALF2;
			col_in_half = '0;
			drop_group();
		end
		if (parse_phase == PH_HALF2) begin
			if (group_chars != 2'd0 || col_in_half < {1'b0, model_half})
				return take_data_char(c, b);
			parse_phase = PH_REST;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Text generation
	// ------------------------------------------------------------------------

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'("0" + v);
		if (v < 16)
			return 8'("a" + v - 10);
		return 8'("A" + v - 16);
	endfunction

	function automatic logic [7:0] other_char();
		logic [7:0] c;
		c = CHAR_NL;
		while (c == CHAR_NL)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] sep_char();
		return ($urandom_range(0, 4) != 0) ? CHAR_SPACE : other_char();
	endfunction

	// Appends roughly one half of data area: mostly digit pairs with a
	// separator, with lone digits, empty groups, digit runs that overflow a
	// group and stray characters mixed in.
	function automatic void fill_half();
		int n;
		int k;
		n = 0;
		while (n < gen_half) begin
			k = $urandom_range(0, 99);
			if (k < 62) begin
				line_chars.push_back(hex_char());
				line_chars.push_back(hex_char());
				line_chars.push_back(sep_char());
				n += 3;
			end else if (k < 77) begin
				line_chars.push_back(hex_char());
				line_chars.push_back(sep_char());
				n += 2;
			end else if (k < 85) begin
				line_chars.push_back(sep_char());
				n += 1;
			end else if (k < 90) begin
				repeat (3) line_chars.push_back(hex_char());
				n += 3;
			end else begin
				line_chars.push_back(other_char());
				n += 1;
			end
		end
	endfunction

	// Queues one line and returns the number of characters queued. Most lines
	// are well formed; some are cut short by a newline, some are left open so
	// that the next line runs on, and some are plain noise bytes.
	function automatic int add_line();
		int roll;
		int keep;
		int added;
		line_chars.delete();
		roll = $urandom_range(0, 99);
		if (roll >= 92) begin
			repeat ($urandom_range(1, 24)) line_chars.push_back(8'($urandom_range(0, 255)));
			line_chars.push_back(CHAR_NL);
		end else begin
			repeat ($urandom_range(1, 8)) line_chars.push_back(hex_char());
			repeat ($urandom_range(1, 3)) line_chars.push_back(CHAR_SPACE);
			fill_half();
			repeat (gen_div)
				line_chars.push_back(($urandom_range(0, 1) != 0) ? CHAR_SPACE : other_char());
			fill_half();
			repeat ($urandom_range(0, 12)) line_chars.push_back(8'($urandom_range(33, 126)));
			line_chars.push_back(CHAR_NL);
		end
		keep = line_chars.size();
		if (roll >= 75 && roll < 92)
			keep = $urandom_range(1, line_chars.size() - 1);
		for (int i = 0; i < keep; i++)
			pending_chars.push_back(line_chars[i]);
		added = keep;
		if (roll >= 75 && roll < 85) begin
			pending_chars.push_back(CHAR_NL);
			added++;
		end
		return added;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(s[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------------

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		if (idx == CFG_HALF_WIDTH)
			gen_half = data;
		else if (idx == CFG_DIV_WIDTH)
			gen_div = data[3:0];
	endtask

	task automatic set_pace(input int gap_pct, input int stall_pct);
		@(posedge clk);
		send_gap_pct   <= gap_pct;
		recv_stall_pct <= stall_pct;
	endtask

	// Waits until every queued character has been taken and every predicted
	// byte has come back, then lets trailing characters settle. Polling runs
	// on the falling edge so it never races the clocked processes.
	task automatic drain();
		@(negedge clk);
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_lines(input int count);
		int made;
		made = 0;
		@(negedge clk);
		while (made < count)
			made += add_line();
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Sender: offers the next queued character unless it rolls an idle cycle.
	// A held item stays on the bus until it is taken.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_chars.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus one long hold-off counted here so that the
	// core's queue fills and it has to push back on the sender.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left     <= HOLD_CYCLES;
			hold_done     <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks bytes leaving the core against the oldest prediction,
	// then feeds accepted characters and register writes to the predictor.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		logic [7:0] want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("out_byte %02h arrived with no byte expected", m_axis_tdata);
					err_count++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_out++;
					if (m_axis_tdata !== want) begin
						$error("out_byte mismatch: expected %02h, actual %02h",
							want, m_axis_tdata);
						err_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				chars_in++;
				if (s_axis_tdata == CHAR_NL)
					lines_in++;
				if (parse_char(s_axis_tdata, want))
					expected_bytes.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_HALF_WIDTH: model_half = cfg_data;
					CFG_DIV_WIDTH:  model_div  = cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake and no write means the
	// core has locked up.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles, %0d bytes still expected.",
					quiet_cycles, expected_bytes.size());
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_pace(36, 62);

		// Directed lines under the reset widths. The first has a pair, a lone
		// digit and a group left open when the newline comes. The second starts
		// with the extreme byte values, has NUL as an ordinary separator and
		// ends with a pair that the newline closes.
		@(negedge clk);
		push_text("A 1f B 7\n");
		pending_chars.push_back(8'hFF);
		pending_chars.push_back(8'h00);
		pending_chars.push_back(CHAR_SPACE);
		pending_chars.push_back(8'h00);
		push_text("cd\n");
		drain();
		// Short half and no divider: the second half follows at once.
		set_reg(CFG_HALF_WIDTH, 6'd3);
		set_reg(CFG_DIV_WIDTH, 6'd0);
		@(negedge clk);
		push_text("z 12|E\n");
		drain();
		// Empty halves: the line drops straight into the ignored rest.
		set_reg(CFG_HALF_WIDTH, 6'd0);
		@(negedge clk);
		push_text("q 5\n");
		drain();

		// Random lines. Widest halves and divider first.
		set_reg(CFG_HALF_WIDTH, 6'd63);
		set_reg(CFG_DIV_WIDTH, 6'd15);
		run_lines(300);
		// One-character halves; the divider write carries junk in its upper
		// bits, and the two unused indexes must change nothing.
		set_reg(CFG_HALF_WIDTH, 6'd1);
		set_reg(CFG_DIV_WIDTH, 6'h30);
		set_reg(CFG_UNUSED_2, 6'($urandom_range(0, 63)));
		set_reg(CFG_UNUSED_3, 6'($urandom_range(0, 63)));
		run_lines(250);

		set_pace(62, 36);
		set_reg(CFG_HALF_WIDTH, 6'($urandom_range(1, 63)));
		set_reg(CFG_DIV_WIDTH, 6'($urandom_range(0, 63)));
		run_lines(300);
		set_reg(CFG_HALF_WIDTH, 6'd0);
		set_reg(CFG_DIV_WIDTH, 6'd7);
		run_lines(60);

		// No idling, and the receiver holds off for a long stretch right as
		// the sender starts streaming.
		set_pace(0, 0);
		set_reg(CFG_HALF_WIDTH, 6'd16);
		set_reg(CFG_DIV_WIDTH, 6'd2);
		@(posedge clk);
		hold_go <= 1'b1;
		run_lines(350);
		set_reg(CFG_HALF_WIDTH, 6'($urandom_range(0, 63)));
		set_reg(CFG_DIV_WIDTH, 6'($urandom_range(0, 63)));
		run_lines(360);

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			err_count++;
		end
		$display("Run covered %0d characters in %0d newline-ended lines, %0d bytes checked.",
			chars_in, lines_in, bytes_out);
		$display("%0d register writes, half widths 0 to 63, dividers 0 to 15, %0d errors.",
			reg_writes, err_count);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
